// ===== src/rrsp_pkg.sv =====
// shared types, constants and request table for the round-robin sensor poller
`timescale 1ns / 1ps

package rrsp_pkg;

    localparam int CH_W     = 4;
    localparam int MASK_W   = 12;
    localparam int DIST_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int CMD_W    = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 48;

    localparam logic [DIST_W-1:0] NO_REPLY      = 16'hFFFF;
    localparam logic [DIST_W-1:0] HEALTH_RESET  = 16'd2000;
    localparam logic [BYTE_W-1:0] REPLY_BYTES   = 8'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEALTH_LIMIT = 1'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_POLL  = 2'd0,
        CMD_REPLY = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [BYTE_W-1:0] address;
        logic [BYTE_W-1:0] register_num;
        logic [BYTE_W-1:0] command;
    } request_t;

    // result item, send_valid in the lowest bit
    typedef struct packed {
        logic              healthy;
        logic [DIST_W-1:0] read_distance;
        logic              timed_out;
        logic [CH_W-1:0]   polled_channel;
        logic [BYTE_W-1:0] send_command;
        logic [BYTE_W-1:0] send_register;
        logic [BYTE_W-1:0] send_address;
        logic              send_valid;
    } result_t;

    typedef struct packed {
        logic            done;
        logic            found;
        logic [CH_W-1:0] channel;
    } scan_status_t;

    function automatic logic [CH_W-1:0] chan_next(input logic [CH_W-1:0] c,
                                                  input logic [CH_W-1:0] last);
        logic [CH_W-1:0] n;
        n = (c == last) ? '0 : c + 4'd1;
        return n;
    endfunction

    function automatic request_t req_rom(input logic [CH_W-1:0] c);
        request_t r;
        case (c)
            4'd0:    r = '{8'hE8, 8'h02, 8'h01};
            4'd1:    r = '{8'hE8, 8'h02, 8'h02};
            4'd2:    r = '{8'hE8, 8'h02, 8'h03};
            4'd3:    r = '{8'hE8, 8'h02, 8'h04};
            4'd4:    r = '{8'hE8, 8'h02, 8'h05};
            4'd5:    r = '{8'hE8, 8'h02, 8'h06};
            4'd6:    r = '{8'hEA, 8'h02, 8'h02};
            4'd7:    r = '{8'hEA, 8'h02, 8'h06};
            4'd8:    r = '{8'hEA, 8'h02, 8'h01};
            4'd9:    r = '{8'hEA, 8'h02, 8'h03};
            4'd10:   r = '{8'hEA, 8'h02, 8'h04};
            4'd11:   r = '{8'hEA, 8'h02, 8'h05};
            default: r = '{8'h00, 8'h00, 8'h00};
        endcase
        return r;
    endfunction

endpackage

// ===== src/rrsp_scan.sv =====
// circular search for the next enabled channel, one mask bit tested per cycle
`timescale 1ns / 1ps

module rrsp_scan
    import rrsp_pkg::*;
#(
    parameter int CHANNELS = 12
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [CH_W-1:0]   start_ch,
    input  logic [MASK_W-1:0] mask,
    output scan_status_t      status
);

    localparam int TRY_W = $clog2(CHANNELS + 1);
    localparam logic [CH_W-1:0]  LAST_CH   = CH_W'(CHANNELS - 1);
    localparam logic [TRY_W-1:0] LAST_TRY  = TRY_W'(CHANNELS - 1);

    logic             active_reg;
    logic [CH_W-1:0]  ch_reg;
    logic [TRY_W-1:0] tries_reg;
    logic             hit;
    logic             last_try;

    assign hit      = mask[ch_reg];
    assign last_try = (tries_reg == LAST_TRY);

    assign status.done    = active_reg && (hit || last_try);
    assign status.found   = active_reg && hit;
    // after a full miss the channel has gone all the way round to its start
    assign status.channel = hit ? ch_reg : chan_next(ch_reg, LAST_CH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            ch_reg     <= '0;
            tries_reg  <= '0;
        end else if (start) begin
            active_reg <= 1'b1;
            ch_reg     <= start_ch;
            tries_reg  <= '0;
        end else if (active_reg) begin
            if (hit || last_try) begin
                active_reg <= 1'b0;
            end else begin
                ch_reg    <= chan_next(ch_reg, LAST_CH);
                tries_reg <= tries_reg + TRY_W'(1);
            end
        end
    end

endmodule

// ===== src/rrsp_dist.sv =====
// per-channel distance registers, cleared at reset
`timescale 1ns / 1ps

module rrsp_dist
    import rrsp_pkg::*;
#(
    parameter int CHANNELS = 12
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic [CH_W-1:0]   wr_addr,
    input  logic [DIST_W-1:0] wr_data,
    input  logic [CH_W-1:0]   rd_addr,
    output logic [DIST_W-1:0] rd_data
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

    logic [DIST_W-1:0] dist_reg [CHANNELS];

    // out-of-range channels read as zero
    assign rd_data = (rd_addr > LAST_CH) ? '0 : dist_reg[rd_addr[IDX_W-1:0]];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                dist_reg[i] <= '0;
            end
        end else if (wr_en && (wr_addr <= LAST_CH)) begin
            dist_reg[wr_addr[IDX_W-1:0]] <= wr_data;
        end
    end

endmodule

// ===== src/round_robin_sensor_poller_top.sv =====
// top level: request handshake, sequencer, channel state and result register
// sequence: idle registers the request, exec runs the command, a poll with a nonzero mask
//   then searches in scan, one mask bit tested per cycle, and emit loads the result
// throughput: one request at a time, next request accepted the cycle after the result loads
// reset: aresetn synchronous active low; clears mask, channel, pending flag, tick count and
//   all stored distances at once, health limit returns to 2000
`timescale 1ns / 1ps

module round_robin_sensor_poller_top
    import rrsp_pkg::*;
#(
    parameter int CHANNELS = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // reply_len[7:0], reply_high[15:8], reply_low[23:16], read_channel[27:24], zero pad
    input  logic [S_DATA_W-1:0]   s_tdata,
    // cmd[1:0]
    input  logic [CMD_W-1:0]      s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // send_valid[0], send_address[8:1], send_register[16:9], send_command[24:17],
    // polled_channel[28:25], timed_out[29], read_distance[45:30], healthy[46], zero pad
    output logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t              state_reg;
    cmd_t                cmd_reg;
    logic [BYTE_W-1:0]   len_reg;
    logic [BYTE_W-1:0]   hi_reg;
    logic [BYTE_W-1:0]   lo_reg;
    logic [CH_W-1:0]     rc_reg;
    logic [CH_W-1:0]     cur_reg;
    logic                await_reg;
    logic [DIST_W-1:0]   ticks_reg;
    logic [MASK_W-1:0]   mask_reg;
    logic [DIST_W-1:0]   limit_reg;
    logic                res_send_reg;
    logic [CH_W-1:0]     res_ch_reg;
    logic                res_timed_reg;
    logic [DIST_W-1:0]   res_read_reg;
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    logic              mask_zero;
    logic [CH_W-1:0]   poll_ch;
    logic              scan_start;
    logic [CH_W-1:0]   scan_ch;
    scan_status_t      scan_st;
    logic              st_we;
    logic [CH_W-1:0]   st_waddr;
    logic [DIST_W-1:0] st_wdata;
    logic [DIST_W-1:0] st_rdata;
    logic              out_free;
    request_t          req;
    result_t           res;

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign mask_zero = (mask_reg == '0);
    assign out_free  = !m_tvalid_reg || m_tready;

    // a stale channel index wraps to zero before a poll uses it
    assign poll_ch = (cur_reg > LAST_CH) ? '0 : cur_reg;

    always_comb begin
        scan_start = 1'b0;
        scan_ch    = poll_ch;
        st_we      = 1'b0;
        st_waddr   = cur_reg;
        st_wdata   = {hi_reg, lo_reg};
        if (state_reg == ST_EXEC) begin
            case (cmd_reg)
                CMD_POLL: begin
                    if (!mask_zero) begin
                        scan_start = 1'b1;
                        if (await_reg) begin
                            // abandon the unanswered request
                            st_we    = 1'b1;
                            st_waddr = poll_ch;
                            st_wdata = NO_REPLY;
                            scan_ch  = chan_next(poll_ch, LAST_CH);
                        end
                    end
                end
                CMD_REPLY: begin
                    st_we = (len_reg == REPLY_BYTES) && await_reg;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        req                 = req_rom(res_ch_reg);
        res.healthy         = mask_zero || (ticks_reg <= limit_reg);
        res.read_distance   = res_read_reg;
        res.timed_out       = res_timed_reg;
        res.polled_channel  = res_ch_reg;
        res.send_command    = res_send_reg ? req.command : '0;
        res.send_register   = res_send_reg ? req.register_num : '0;
        res.send_address    = res_send_reg ? req.address : '0;
        res.send_valid      = res_send_reg;
    end

    rrsp_scan #(
        .CHANNELS(CHANNELS)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (scan_start),
        .start_ch(scan_ch),
        .mask    (mask_reg),
        .status  (scan_st)
    );

    rrsp_dist #(
        .CHANNELS(CHANNELS)
    ) u_dist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (st_we),
        .wr_addr (st_waddr),
        .wr_data (st_wdata),
        .rd_addr (rc_reg),
        .rd_data (st_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cur_reg       <= '0;
            await_reg     <= 1'b0;
            ticks_reg     <= '0;
            mask_reg      <= '0;
            limit_reg     <= HEALTH_RESET;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_ENABLE_MASK:  mask_reg  <= cfg_wdata[MASK_W-1:0];
                    REG_HEALTH_LIMIT: limit_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end

            // the emit state reloads the result register itself
            if (m_tvalid_reg && m_tready && (state_reg != ST_EMIT)) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        cmd_reg       <= cmd_t'(s_tuser);
                        len_reg       <= s_tdata[7:0];
                        hi_reg        <= s_tdata[15:8];
                        lo_reg        <= s_tdata[23:16];
                        rc_reg        <= s_tdata[27:24];
                        res_send_reg  <= 1'b0;
                        res_ch_reg    <= '0;
                        res_timed_reg <= 1'b0;
                        res_read_reg  <= '0;
                        state_reg     <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    state_reg <= ST_EMIT;
                    case (cmd_reg)
                        CMD_POLL: begin
                            if (!mask_zero) begin
                                if (await_reg) begin
                                    res_timed_reg <= 1'b1;
                                    await_reg     <= 1'b0;
                                end
                                state_reg <= ST_SCAN;
                            end
                        end
                        CMD_REPLY: begin
                            if ((len_reg == REPLY_BYTES) && await_reg) begin
                                cur_reg   <= cur_reg + 4'd1;
                                await_reg <= 1'b0;
                                ticks_reg <= '0;
                            end
                        end
                        CMD_TICK: begin
                            if (ticks_reg != NO_REPLY) begin
                                ticks_reg <= ticks_reg + 16'd1;
                            end
                        end
                        CMD_READ: begin
                            res_read_reg <= st_rdata;
                        end
                        default: begin
                        end
                    endcase
                end
                ST_SCAN: begin
                    if (scan_st.done) begin
                        cur_reg   <= scan_st.channel;
                        state_reg <= ST_EMIT;
                        if (scan_st.found) begin
                            await_reg    <= 1'b1;
                            res_send_reg <= 1'b1;
                            res_ch_reg   <= scan_st.channel;
                        end
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {1'b0, res};
                        if (mask_zero) begin
                            ticks_reg <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // a pending request always refers to a real channel
    a_await_channel: assert property (@(posedge aclk) disable iff (!aresetn)
        await_reg |-> (cur_reg <= LAST_CH))
        else $error("pending request on out-of-range channel");

    // the scan unit only reports while the sequencer waits for it
    a_scan_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_st.done |-> (state_reg == ST_SCAN))
        else $error("scan finished outside the scan state");

    // a request becomes pending only through a successful search
    a_await_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(await_reg) |-> ($past(state_reg) == ST_SCAN) && $past(scan_st.found))
        else $error("pending flag set without a search hit");
`endif

endmodule
